@@ hw/rtl/rtc3w_pkg.sv @@
// Shared types and constants for the three-wire RTC serial master.
// Used by every RTL module of the block and by the testbench.
`default_nettype none

package rtc3w_pkg;

   // Request codes on the input channel.
   localparam logic [1:0] REQ_TICK  = 2'd0;
   localparam logic [1:0] REQ_WRITE = 2'd1;
   localparam logic [1:0] REQ_READ  = 2'd2;

   // Command byte framing.
   localparam logic [7:0] CMD_BASE  = 8'h80;
   localparam logic       READ_FLAG = 1'b1;

   // Bit counts of one access: command byte plus data byte.
   localparam logic [4:0] TOTAL_BITS = 5'd16;
   localparam logic [4:0] DATA_BITS  = 5'd8;

   // Reset value of the half period register.
   localparam logic [7:0] HALF_PERIOD_RESET = 8'd4;

   // Queue between the front and back ends.
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_LW    = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_SETUP,
      PH_LOW,
      PH_HIGH,
      PH_HOLD
   } phase_type;

   // One classified tick as it travels through the queue.
   typedef struct packed {
      logic        start;
      logic        is_read;
      logic [15:0] tx_word;
      logic        din;
   } entry_type;

   // Queue fill status seen by the front end, the back end and the top level.
   typedef struct packed {
      logic [QUEUE_LW-1:0] level;
      logic                full;
      logic                empty;
   } queue_status_type;

   // One result beat as held in the output register.
   typedef struct packed {
      logic       serial_clock;
      logic       serial_data_out;
      logic       data_drive;
      logic       chip_enable;
      logic       busy_res;
      logic [7:0] read_data;
      logic       read_done;
   } result_type;

endpackage

`default_nettype wire

@@ hw/rtl/rtc3w_if.sv @@
// Valid/ready channel interfaces for requests, results and configuration.
// Depends on nothing but the port widths of the block.
`default_nettype none

interface rtc3w_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] req_type;
   logic       ram_select;
   logic [4:0] reg_addr;
   logic [7:0] write_data;
   logic       serial_data_in;

   modport source (output valid, req_type, ram_select, reg_addr, write_data,
                   serial_data_in, input ready);
   modport sink   (input valid, req_type, ram_select, reg_addr, write_data,
                   serial_data_in, output ready);
endinterface

interface rtc3w_rsp_if;
   logic       valid;
   logic       ready;
   logic       serial_clock;
   logic       serial_data_out;
   logic       data_drive;
   logic       chip_enable;
   logic       busy_res;
   logic [7:0] read_data;
   logic       read_done;

   modport source (output valid, serial_clock, serial_data_out, data_drive,
                   chip_enable, busy_res, read_data, read_done, input ready);
   modport sink   (input valid, serial_clock, serial_data_out, data_drive,
                   chip_enable, busy_res, read_data, read_done, output ready);
endinterface

interface rtc3w_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] half_period_ticks;

   modport source (output valid, half_period_ticks, input ready);
   modport sink   (input valid, half_period_ticks, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/rtc3w_front.sv @@
// Front end: accepts request beats and classifies them into queue entries.
// Depends on rtc3w_pkg and rtc3w_req_if.
`default_nettype none

module rtc3w_front
   import rtc3w_pkg::*;
(
   rtc3w_req_if.sink        req_bus,
   input  queue_status_type q_status,
   output logic             push,
   output entry_type        push_entry
);

   logic       is_start;
   logic       is_read;
   logic [7:0] cmd_byte;

   // A beat is taken whenever the queue has room.
   assign req_bus.ready = !q_status.full;
   assign push          = req_bus.valid && !q_status.full;

   // Decode the request and build the command byte.
   always_comb begin
      is_start = (req_bus.req_type == REQ_WRITE) || (req_bus.req_type == REQ_READ);
      is_read  = (req_bus.req_type == REQ_READ);
      cmd_byte = CMD_BASE | {1'b0, req_bus.ram_select, req_bus.reg_addr, 1'b0};
      if (is_read) begin
         cmd_byte[0] = READ_FLAG;
      end
   end

   // A read sends only the command; a write appends the data byte.
   always_comb begin
      push_entry.start   = is_start;
      push_entry.is_read = is_read;
      push_entry.din     = req_bus.serial_data_in;
      if (is_read) begin
         push_entry.tx_word = {8'h00, cmd_byte};
      end else begin
         push_entry.tx_word = {req_bus.write_data, cmd_byte};
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/rtc3w_queue.sv @@
// Short first-in first-out queue of classified ticks between front and back.
// Depends on rtc3w_pkg for the entry type and depth.
`default_nettype none

module rtc3w_queue
   import rtc3w_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  entry_type        push_entry,
   input  logic             pop,
   output entry_type        pop_entry,
   output queue_status_type status
);

   entry_type           entries_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_LW-1:0] level_ff, level_in;

   // Pointer and level updates; pointers wrap at the queue depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         level_in = level_ff + 1'b1;
      end else if (pop && !push) begin
         level_in = level_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign pop_entry     = entries_ff[rd_ptr_ff];
   assign status.level  = level_ff;
   assign status.full   = (level_ff == QUEUE_LW'(QUEUE_DEPTH));
   assign status.empty  = (level_ff == '0);

endmodule

`default_nettype wire

@@ hw/rtl/rtc3w_back.sv @@
// Back end: runs the serial sequencer one tick per queue entry and holds
// the result beat in an output register. Depends on rtc3w_pkg, rtc3w_rsp_if.
`default_nettype none

module rtc3w_back
   import rtc3w_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic [7:0]       half_period,
   input  queue_status_type q_status,
   input  entry_type        entry,
   output logic             pop,
   rtc3w_rsp_if.source      rsp_bus
);

   phase_type   phase_ff, phase_in;
   logic [7:0]  div_ff, div_in;
   logic [4:0]  bit_cnt_ff, bit_cnt_in;
   logic [15:0] tx_ff, tx_in;
   logic [7:0]  rx_ff, rx_in;
   logic        is_read_ff, is_read_in;
   result_type  res_ff, res_in;
   logic        res_valid_ff, res_valid_in;

   logic        phase_end;
   logic [4:0]  bit_cnt_inc;
   logic        released;
   logic        read_done_in;

   // Take a tick when one is queued and the output register is free.
   assign pop = !q_status.empty && (!res_valid_ff || rsp_bus.ready);

   assign phase_end   = ({1'b0, div_ff} + 9'd1) >= {1'b0, half_period};
   assign bit_cnt_inc = bit_cnt_ff + 5'd1;

   // Next phase of the sequencer.
   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         PH_IDLE: begin
            if (entry.start) begin
               phase_in = PH_SETUP;
            end
         end
         PH_SETUP: begin
            if (phase_end) begin
               phase_in = PH_LOW;
            end
         end
         PH_LOW: begin
            if (phase_end) begin
               phase_in = PH_HIGH;
            end
         end
         PH_HIGH: begin
            if (phase_end) begin
               phase_in = (bit_cnt_inc >= TOTAL_BITS) ? PH_HOLD : PH_LOW;
            end
         end
         PH_HOLD: begin
            if (phase_end) begin
               phase_in = PH_IDLE;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   // Datapath updates: divider, bit counter, shift registers.
   always_comb begin
      div_in       = div_ff;
      bit_cnt_in   = bit_cnt_ff;
      tx_in        = tx_ff;
      rx_in        = rx_ff;
      is_read_in   = is_read_ff;
      read_done_in = 1'b0;
      if (phase_ff == PH_IDLE) begin
         if (entry.start) begin
            is_read_in = entry.is_read;
            tx_in      = entry.tx_word;
            bit_cnt_in = '0;
            div_in     = '0;
         end
      end else if (phase_end) begin
         div_in = '0;
         case (phase_ff)
            PH_SETUP: begin
               bit_cnt_in = '0;
            end
            PH_LOW: begin
               // Sample the line just before the rising edge of a data bit.
               if (is_read_ff && (bit_cnt_ff >= DATA_BITS)) begin
                  rx_in[bit_cnt_ff[2:0]] = entry.din;
               end
            end
            PH_HIGH: begin
               bit_cnt_in = bit_cnt_inc;
               tx_in      = {1'b0, tx_ff[15:1]};
            end
            default: begin
               read_done_in = is_read_ff;
            end
         endcase
      end else begin
         div_in = div_ff + 8'd1;
      end
   end

   // Pin levels follow the state after this tick.
   always_comb begin
      released = is_read_in && (bit_cnt_in >= DATA_BITS) &&
                 ((phase_in == PH_LOW) || (phase_in == PH_HIGH) || (phase_in == PH_HOLD));
      res_in.busy_res        = (phase_in != PH_IDLE);
      res_in.chip_enable     = (phase_in != PH_IDLE);
      res_in.serial_clock    = (phase_in == PH_HIGH);
      res_in.read_data       = rx_in;
      res_in.read_done       = read_done_in;
      res_in.data_drive      = !released;
      res_in.serial_data_out = !released &&
                               ((phase_in == PH_LOW) || (phase_in == PH_HIGH)) && tx_in[0];
   end

   // Output register valid: set on a new tick, cleared when drained.
   always_comb begin
      res_valid_in = res_valid_ff;
      if (pop) begin
         res_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         res_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         div_ff       <= '0;
         bit_cnt_ff   <= '0;
         tx_ff        <= '0;
         rx_ff        <= '0;
         is_read_ff   <= 1'b0;
         res_valid_ff <= 1'b0;
      end else begin
         res_valid_ff <= res_valid_in;
         if (pop) begin
            phase_ff   <= phase_in;
            div_ff     <= div_in;
            bit_cnt_ff <= bit_cnt_in;
            tx_ff      <= tx_in;
            rx_ff      <= rx_in;
            is_read_ff <= is_read_in;
         end
      end
   end

   // Result payload needs no reset.
   always_ff @(posedge clock) begin
      if (pop) begin
         res_ff <= res_in;
      end
   end

   assign rsp_bus.valid           = res_valid_ff;
   assign rsp_bus.serial_clock    = res_ff.serial_clock;
   assign rsp_bus.serial_data_out = res_ff.serial_data_out;
   assign rsp_bus.data_drive      = res_ff.data_drive;
   assign rsp_bus.chip_enable     = res_ff.chip_enable;
   assign rsp_bus.busy_res        = res_ff.busy_res;
   assign rsp_bus.read_data       = res_ff.read_data;
   assign rsp_bus.read_done       = res_ff.read_done;

endmodule

`default_nettype wire

@@ hw/rtl/three_wire_rtc_serial_master_top.sv @@
// Three-wire RTC serial master: usage notes
//
// Every request beat is one system tick. A tick with req_type write or read
// starts a single-byte access when the master is idle; otherwise it only
// advances the serial timing. Each request beat yields exactly one result
// beat carrying the pin levels (serial_clock, serial_data_out, data_drive,
// chip_enable), busy_res, the receive register and a one-tick read_done.
// A request passes through the queue, then into the result register.
// Throughput is one beat per cycle while the result side stays ready, set by
// the back-end sequencer, which handles one queued tick per cycle.
// A two-entry queue separates the request side from the sequencer, and the
// result register lets a new request be taken while a result waits.
// When the result side stalls the sequencer holds, the queue fills and then
// req_bus.ready drops; no beat is lost or repeated.
// The csr channel writes half_period_ticks (reset 4); it is always ready. The user
// must write it only while no beat is queued or waiting in the result register;
// the block does not enforce this. Reset (synchronous, active high) empties the
// queue, clears the result valid flag and returns the sequencer to idle with all
// shift state zero. Depends on rtc3w_pkg, channel interfaces, front, queue, back.
`default_nettype none

module three_wire_rtc_serial_master_top
   import rtc3w_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   rtc3w_req_if.sink   req_bus,
   rtc3w_rsp_if.source rsp_bus,
   rtc3w_csr_if.sink   csr_bus
);

   logic [7:0]       half_period_ff, half_period_in;
   queue_status_type q_status;
   logic             push;
   entry_type        push_entry;
   logic             pop;
   entry_type        pop_entry;

   // Configuration register.
   assign csr_bus.ready = 1'b1;

   always_comb begin
      half_period_in = half_period_ff;
      if (csr_bus.valid) begin
         half_period_in = csr_bus.half_period_ticks;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         half_period_ff <= HALF_PERIOD_RESET;
      end else begin
         half_period_ff <= half_period_in;
      end
   end

   rtc3w_front u_front (
      .req_bus    (req_bus),
      .q_status   (q_status),
      .push       (push),
      .push_entry (push_entry)
   );

   rtc3w_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .status     (q_status)
   );

   rtc3w_back u_back (
      .clock       (clock),
      .reset       (reset),
      .half_period (half_period_ff),
      .q_status    (q_status),
      .entry       (pop_entry),
      .pop         (pop),
      .rsp_bus     (rsp_bus)
   );

   // The queue level never passes its depth.
   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      q_status.level <= QUEUE_LW'(QUEUE_DEPTH))
      else $error("queue level beyond depth");

   // A tick is never pushed into a full queue.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |-> !q_status.full)
      else $error("push into full queue");

   // A released data line is never driven high and only occurs with enable up.
   a_release: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && !rsp_bus.data_drive) |->
         (!rsp_bus.serial_data_out && rsp_bus.chip_enable))
      else $error("released line driven or enable low");

   // Reset leaves no result pending.
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_bus.valid)
      else $error("result valid after reset");

endmodule

`default_nettype wire

@@ verif/tb.sv @@
// Self-checking testbench for the three-wire RTC serial master.
// Needs rtc3w_pkg, the channel interfaces and the top-level RTL; it predicts
// every result beat with its own tick-level sequencer and compares field by field.

module tb;
   import rtc3w_pkg::*;

   // Request code with no meaning; the block treats it as a plain tick.
   localparam logic [1:0] REQ_UNUSED = 2'd3;

   localparam int RESET_CYCLES   = 12;
   localparam int IDLE_PERCENT   = 30;
   localparam int HOLD_CYCLES    = 80;
   localparam int STALL_LIMIT    = 2000;
   localparam int DRAIN_GAP      = 4;
   localparam int SETTLE_CYCLES  = 10;
   localparam int REPORT_LIMIT   = 10;
   localparam int ITEMS_PER_RATE = 50;
   localparam int SLOW_TICKS     = 270;
   localparam int RATE_COUNT     = 6;
   localparam logic [7:0] RANDOM_RATES [RATE_COUNT] = '{8'd1, 8'd0, 8'd3, 8'd2, 8'd7, 8'd4};

   logic clock = 1'b0;
   logic reset = 1'b1;

   rtc3w_req_if req_bus ();
   rtc3w_rsp_if rsp_bus ();
   rtc3w_csr_if csr_bus ();

   three_wire_rtc_serial_master_top dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // Free-running clock with a period of 10.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Sequencer state as the testbench sees it, plus the programmed rate.
   phase_type   seq_phase;
   logic [7:0]  seq_div;
   logic [4:0]  seq_bits;
   logic [15:0] seq_tx;
   logic [7:0]  seq_rx;
   logic        seq_is_read;
   logic [7:0]  half_period;

   result_type  pin_forecast [$];
   int          error_count = 0;
   bit          calm = 1'b0;
   logic        hold_trigger = 1'b0;
   int          hold_left;
   int          quiet_cycles = 0;

   // Advance the sequencer by one tick and return the pin levels after it.
   function automatic result_type advance_sequencer(input logic [1:0] kind, input logic ram,
                                                    input logic [4:0] addr,
                                                    input logic [7:0] wdata, input logic din);
      result_type pins;
      logic [7:0] cmd;
      logic       done;
      logic       released;
      done = 1'b0;
      if (seq_phase == PH_IDLE) begin
         if (kind == REQ_WRITE || kind == REQ_READ) begin
            seq_is_read = (kind == REQ_READ);
            cmd = CMD_BASE | {1'b0, ram, addr, seq_is_read ? READ_FLAG : 1'b0};
            seq_tx = seq_is_read ? {8'h00, cmd} : {wdata, cmd};
            seq_bits = '0;
            seq_div = '0;
            seq_phase = PH_SETUP;
         end
      end else if (int'(seq_div) + 1 >= int'(half_period)) begin
         seq_div = '0;
         case (seq_phase)
            PH_SETUP: begin
               seq_bits = '0;
               seq_phase = PH_LOW;
            end
            PH_LOW: begin
               // Data bits are sampled just before the rising edge.
               if (seq_is_read && seq_bits >= DATA_BITS)
                  seq_rx[seq_bits[2:0]] = din;
               seq_phase = PH_HIGH;
            end
            PH_HIGH: begin
               seq_bits = seq_bits + 5'd1;
               seq_tx = seq_tx >> 1;
               seq_phase = (seq_bits >= TOTAL_BITS) ? PH_HOLD : PH_LOW;
            end
            default: begin
               done = seq_is_read;
               seq_phase = PH_IDLE;
            end
         endcase
      end else begin
         seq_div = seq_div + 8'd1;
      end

      pins = '0;
      pins.data_drive = 1'b1;
      if (seq_phase != PH_IDLE) begin
         released = seq_is_read && seq_bits >= DATA_BITS && seq_phase != PH_SETUP;
         pins.chip_enable = 1'b1;
         pins.serial_clock = (seq_phase == PH_HIGH);
         if (released) begin
            pins.data_drive = 1'b0;
         end else begin
            pins.serial_data_out = (seq_phase == PH_LOW || seq_phase == PH_HIGH) && seq_tx[0];
         end
      end
      pins.busy_res = (seq_phase != PH_IDLE);
      pins.read_data = seq_rx;
      pins.read_done = done;
      return pins;
   endfunction

   function automatic bit take_gap();
      return !calm && ($urandom_range(99) < IDLE_PERCENT);
   endfunction

   // Mostly starts while idle; mostly ticks while an access runs.
   function automatic logic [1:0] pick_kind();
      int roll;
      roll = $urandom_range(99);
      if (seq_phase == PH_IDLE) begin
         if (roll < 45) return REQ_WRITE;
         if (roll < 90) return REQ_READ;
         if (roll < 95) return REQ_UNUSED;
         return REQ_TICK;
      end
      if (roll < 85) return REQ_TICK;
      if (roll < 90) return REQ_WRITE;
      if (roll < 95) return REQ_READ;
      return REQ_UNUSED;
   endfunction

   task automatic note_failure(input string msg);
      if (error_count < REPORT_LIMIT)
         $display("%s", msg);
      error_count++;
   endtask

   task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (want !== got)
         note_failure($sformatf("%s mismatch: expected %0h, got %0h", name, want, got));
   endtask

   // Offer one tick beat and predict its result once it is accepted.
   task automatic send_tick(input logic [1:0] kind, input logic ram, input logic [4:0] addr,
                            input logic [7:0] wdata, input logic din);
      while (take_gap()) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid          <= 1'b1;
      req_bus.req_type       <= kind;
      req_bus.ram_select     <= ram;
      req_bus.reg_addr       <= addr;
      req_bus.write_data     <= wdata;
      req_bus.serial_data_in <= din;
      do @(posedge clock); while (!req_bus.ready);
      pin_forecast.push_back(advance_sequencer(kind, ram, addr, wdata, din));
   endtask

   task automatic send_random(input logic [1:0] kind);
      send_tick(kind, 1'($urandom_range(1)), 5'($urandom_range(31)),
                8'($urandom_range(255)), 1'($urandom_range(1)));
   endtask

   // Tick until the running access ends; optionally mix in ignored starts.
   task automatic finish_access(input bit mixed_kinds, input bit fixed_din,
                                input logic din_level);
      while (seq_phase != PH_IDLE) begin
         send_tick(mixed_kinds ? pick_kind() : REQ_TICK, 1'($urandom_range(1)),
                   5'($urandom_range(31)), 8'($urandom_range(255)),
                   fixed_din ? din_level : logic'($urandom_range(1)));
      end
   endtask

   // Stop offering beats and wait for every predicted result.
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (pin_forecast.size() != 0) @(posedge clock);
      repeat (DRAIN_GAP) @(posedge clock);
   endtask

   task automatic write_half_period(input logic [7:0] value);
      wait_drained();
      csr_bus.valid             <= 1'b1;
      csr_bus.half_period_ticks <= value;
      do @(posedge clock); while (!csr_bus.ready);
      half_period = value;
      csr_bus.valid <= 1'b0;
   endtask

   // A write at the reset rate with RAM select and every address and data bit set.
   task automatic test_reset_rate();
      send_tick(REQ_WRITE, 1'b1, 5'd31, 8'hFF, 1'b0);
      finish_access(1'b0, 1'b1, 1'b0);
   endtask

   // Writes with all-zero fields and a mixed pattern at the fastest rate.
   task automatic test_write_patterns();
      write_half_period(8'd1);
      send_tick(REQ_WRITE, 1'b0, 5'd0, 8'h00, 1'b1);
      finish_access(1'b0, 1'b1, 1'b1);
      send_tick(REQ_WRITE, 1'b1, 5'd10, 8'hA5, 1'b0);
      finish_access(1'b0, 1'b0, 1'b0);
   endtask

   // Reads with the data line held high then low, at a zero half period.
   task automatic test_read_levels();
      write_half_period(8'd0);
      send_tick(REQ_READ, 1'b0, 5'd31, 8'h00, 1'b1);
      finish_access(1'b0, 1'b1, 1'b1);
      send_tick(REQ_READ, 1'b1, 5'd0, 8'hFF, 1'b0);
      finish_access(1'b0, 1'b1, 1'b0);
   endtask

   // Starts while busy and the unused request code are plain ticks.
   task automatic test_ignored_starts();
      write_half_period(8'd2);
      send_tick(REQ_UNUSED, 1'b1, 5'd5, 8'h3C, 1'b1);
      send_tick(REQ_WRITE, 1'b0, 5'd21, 8'hC3, 1'b0);
      send_tick(REQ_READ, 1'b1, 5'd31, 8'hFF, 1'b1);
      send_tick(REQ_WRITE, 1'b1, 5'd31, 8'hFF, 1'b1);
      send_tick(REQ_UNUSED, 1'b1, 5'd31, 8'hFF, 1'b1);
      finish_access(1'b0, 1'b0, 1'b0);
      send_tick(REQ_TICK, 1'b1, 5'd31, 8'hFF, 1'b1);
   endtask

   // The half period shrinks while a read sits in the middle of a phase.
   task automatic test_rate_drop();
      write_half_period(8'd8);
      send_tick(REQ_READ, 1'b0, 5'd7, 8'h00, 1'b1);
      repeat (13) send_random(REQ_TICK);
      write_half_period(8'd1);
      finish_access(1'b0, 1'b0, 1'b0);
   endtask

   // The result side stalls for a long stretch while beats keep coming.
   task automatic test_result_stall();
      write_half_period(8'd1);
      calm = 1'b1;
      hold_trigger <= 1'b1;
      @(posedge clock);
      hold_trigger <= 1'b0;
      send_random(REQ_WRITE);
      repeat (40) send_random(REQ_TICK);
      finish_access(1'b0, 1'b0, 1'b0);
      calm = 1'b0;
   endtask

   // Random traffic over several rates, one of them without any idling.
   task automatic test_random_traffic();
      for (int r = 0; r < RATE_COUNT; r++) begin
         write_half_period(RANDOM_RATES[r]);
         calm = (r == 2);
         repeat (ITEMS_PER_RATE) send_random(pick_kind());
         finish_access(1'b1, 1'b0, 1'b0);
      end
      calm = 1'b0;
   endtask

   // At the slowest rate the setup phase runs its full length; the rate is
   // then raised so the rest of the read finishes quickly.
   task automatic test_slowest_rate();
      write_half_period(8'd255);
      send_random(REQ_READ);
      repeat (SLOW_TICKS) send_random(REQ_TICK);
      write_half_period(8'd1);
      finish_access(1'b1, 1'b0, 1'b0);
   endtask

   // Result side: random stalls, or a counted hold when asked for one.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         hold_left <= 0;
      end else if (hold_trigger) begin
         rsp_bus.ready <= 1'b0;
         hold_left <= HOLD_CYCLES - 1;
      end else if (hold_left != 0) begin
         rsp_bus.ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else begin
         rsp_bus.ready <= !take_gap();
      end
   end

   // Compare each accepted result beat with the oldest prediction.
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pin_forecast.size() == 0) begin
            note_failure("result beat arrived with no prediction pending");
         end else begin
            want = pin_forecast.pop_front();
            check_field("serial_clock", 8'(want.serial_clock), 8'(rsp_bus.serial_clock));
            check_field("serial_data_out", 8'(want.serial_data_out),
                        8'(rsp_bus.serial_data_out));
            check_field("data_drive", 8'(want.data_drive), 8'(rsp_bus.data_drive));
            check_field("chip_enable", 8'(want.chip_enable), 8'(rsp_bus.chip_enable));
            check_field("busy_res", 8'(want.busy_res), 8'(rsp_bus.busy_res));
            check_field("read_data", want.read_data, rsp_bus.read_data);
            check_field("read_done", 8'(want.read_done), 8'(rsp_bus.read_done));
         end
      end
   end

   // Watchdog: too many cycles in a row with no beat moving on any channel.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || (csr_bus.valid && csr_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      req_bus.valid = 1'b0;
      req_bus.req_type = REQ_TICK;
      req_bus.ram_select = 1'b0;
      req_bus.reg_addr = '0;
      req_bus.write_data = '0;
      req_bus.serial_data_in = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.half_period_ticks = '0;
      seq_phase = PH_IDLE;
      seq_div = '0;
      seq_bits = '0;
      seq_tx = '0;
      seq_rx = '0;
      seq_is_read = 1'b0;
      half_period = HALF_PERIOD_RESET;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_reset_rate();
      test_write_patterns();
      test_read_levels();
      test_ignored_starts();
      test_rate_drop();
      test_result_stall();
      test_random_traffic();
      test_slowest_rate();

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0 && pin_forecast.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

@@ sim.f @@
hw/rtl/rtc3w_pkg.sv
hw/rtl/rtc3w_if.sv
hw/rtl/rtc3w_front.sv
hw/rtl/rtc3w_queue.sv
hw/rtl/rtc3w_back.sv
hw/rtl/three_wire_rtc_serial_master_top.sv
verif/tb.sv
